>>> design/b64c_pkg.sv
// shared types, constants and alphabet functions for the base64 codec
`default_nettype none

package b64c_pkg;

   // default depth of the job queue between front and back
   localparam int JOB_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR     = 8'h3d;  // '='
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;

   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   // one burst of up to four result words, word 0 goes out first
   typedef struct packed {
      logic [3:0][7:0] words;
      logic [1:0]      last_idx;
   } job_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v8 < 8'd26) begin
         return CHAR_UPPER_A + v8;
      end else if (v8 < 8'd52) begin
         return CHAR_LOWER_A + (v8 - 8'd26);
      end else if (v8 < 8'd62) begin
         return CHAR_DIGIT_0 + (v8 - 8'd52);
      end else if (v8 == 8'd62) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

   // characters outside the alphabet map to zero
   function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         t = c - CHAR_UPPER_A;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         t = (c - CHAR_LOWER_A) + 8'd26;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         t = (c - CHAR_DIGIT_0) + 8'd52;
      end else if (c == CHAR_PLUS) begin
         t = 8'd62;
      end else if (c == CHAR_SLASH) begin
         t = 8'd63;
      end
      return t[5:0];
   endfunction

endpackage

`default_nettype wire

>>> design/base64_codec_top.sv
// top level of the streaming base64 codec
`default_nettype none

// Streaming Base64 codec, standard alphabet A-Z a-z 0-9 + / with '=' padding.
// csr_wdata written with csr_we selects the direction (0 encode, 1 decode);
// every write also drops any partly gathered group. Write it only while the
// block is idle. Encode takes one raw byte per word; each third byte yields
// four characters, and a word with end_of_message set flushes a one- or
// two-byte remainder as four characters ending in '=' padding. Decode takes
// one character per word and yields up to three bytes per four characters,
// fewer when the group ends in '=' padding; an incomplete final group is
// dropped and characters outside the alphabet count as zero. rsp_run_last
// marks the last result word caused by one input word. The front end takes
// one input word per cycle while the job queue has room, so it accepts the
// next word while earlier results still wait. The back end hands out one
// result word per cycle while the queue holds a burst and pop is high; in
// encode the result port bounds throughput, as three input bytes yield four
// result words, in decode the input port does. A group's burst is written
// into the job queue registers, from which the back end hands it out.

module base64_codec_top #(
   parameter int JobDepth = b64c_pkg::JOB_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   // direction register
   input  wire        csr_we,
   input  wire        csr_wdata,
   // input words
   input  wire        push,
   output logic       full,
   input  wire  [7:0] req_data_byte,
   input  wire        req_end_of_message,
   // result words
   output logic       empty,
   input  wire        pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import b64c_pkg::*;

   // burst handed from front to queue
   logic    fe_push;
   job_type fe_job;
   logic    q_full;

   // head of the queue seen by the back end
   job_type q_head;
   logic    q_empty;
   logic    be_pop;

   // front end: group assembly and character/byte mapping
   b64c_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_push           (push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_full           (full),
      .job_push           (fe_push),
      .job_data           (fe_job),
      .job_full           (q_full)
   );

   // decouples the two ends so either may stall alone
   b64c_job_fifo #(
      .Depth (JobDepth)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_job),
      .full      (q_full),
      .pop       (be_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   // back end: one result word per pop
   b64c_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_empty    (q_empty),
      .job_data     (q_head),
      .job_pop      (be_pop),
      .rsp_empty    (empty),
      .rsp_pop      (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

>>> design/b64c_front.sv
// front end: takes input words, gathers groups, builds result bursts
`default_nettype none

module b64c_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire               csr_wdata,
   input  wire               req_push,
   input  wire  [7:0]        req_data_byte,
   input  wire               req_end_of_message,
   output logic              req_full,
   output logic              job_push,
   output b64c_pkg::job_type job_data,
   input  wire               job_full
);
   import b64c_pkg::*;

   dir_type     dir_ff;
   logic [17:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [1:0]  pad_count_ff, pad_count_in;

   logic        accept;
   logic [23:0] enc_acc;
   logic [23:0] dec_acc;
   logic [1:0]  pad_next;
   logic [1:0]  pad_clip;
   logic        is_pad;
   logic [5:0]  sextet;
   logic        emit;

   assign req_full = job_full;
   assign accept   = req_push & ~job_full;

   always_comb begin
      enc_acc  = {group_bits_ff[15:0], req_data_byte};
      is_pad   = (group_count_ff[1] == 1'b1) && (req_data_byte == PAD_CHAR);
      sextet   = is_pad ? 6'd0 : char_to_sextet(req_data_byte);
      dec_acc  = {group_bits_ff, sextet};
      pad_next = pad_count_ff + {1'b0, is_pad};
      pad_clip = (pad_next > 2'd2) ? 2'd2 : pad_next;

      emit           = 1'b0;
      job_data       = '0;
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      pad_count_in   = pad_count_ff;

      if (dir_ff == DIR_ENCODE) begin
         if (group_count_ff == 2'd2) begin
            emit              = 1'b1;
            job_data.words[0] = sextet_to_char(enc_acc[23:18]);
            job_data.words[1] = sextet_to_char(enc_acc[17:12]);
            job_data.words[2] = sextet_to_char(enc_acc[11:6]);
            job_data.words[3] = sextet_to_char(enc_acc[5:0]);
            job_data.last_idx = 2'd3;
         end else if (req_end_of_message) begin
            emit              = 1'b1;
            job_data.last_idx = 2'd3;
            if (group_count_ff == 2'd0) begin
               // one byte left: two characters and two pads
               job_data.words[0] = sextet_to_char(req_data_byte[7:2]);
               job_data.words[1] = sextet_to_char({req_data_byte[1:0], 4'b0000});
               job_data.words[2] = PAD_CHAR;
               job_data.words[3] = PAD_CHAR;
            end else begin
               // two bytes left: three characters and one pad
               job_data.words[0] = sextet_to_char(enc_acc[15:10]);
               job_data.words[1] = sextet_to_char(enc_acc[9:4]);
               job_data.words[2] = sextet_to_char({enc_acc[3:0], 2'b00});
               job_data.words[3] = PAD_CHAR;
            end
         end else begin
            group_bits_in  = enc_acc[17:0];
            group_count_in = group_count_ff + 2'd1;
         end
      end else begin
         if (group_count_ff == 2'd3) begin
            emit              = 1'b1;
            job_data.words[0] = dec_acc[23:16];
            job_data.words[1] = dec_acc[15:8];
            job_data.words[2] = dec_acc[7:0];
            job_data.last_idx = 2'd2 - pad_clip;
         end else if (!req_end_of_message) begin
            group_bits_in  = dec_acc[17:0];
            group_count_in = group_count_ff + 2'd1;
            pad_count_in   = pad_next;
         end
      end

      // a finished group or end of message starts a fresh group
      if (emit || req_end_of_message) begin
         group_bits_in  = '0;
         group_count_in = '0;
         pad_count_in   = '0;
      end
   end

   assign job_push = accept & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff         <= DIR_ENCODE;
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         pad_count_ff   <= '0;
      end else if (csr_we) begin
         dir_ff         <= dir_type'(csr_wdata);
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         pad_count_ff   <= '0;
      end else if (accept) begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         pad_count_ff   <= pad_count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/b64c_job_fifo.sv
// small queue of result bursts between front and back
`default_nettype none

module b64c_job_fifo #(
   parameter int Depth = b64c_pkg::JOB_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  b64c_pkg::job_type push_data,
   output logic              full,
   input  wire               pop,
   output b64c_pkg::job_type pop_data,
   output logic              empty
);
   import b64c_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   job_type               slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/b64c_back.sv
// back end: walks a queued burst out one result word at a time
`default_nettype none

module b64c_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               job_empty,
   input  b64c_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last
);
   import b64c_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       taken;

   assign rsp_empty    = job_empty;
   assign rsp_out_byte = job_data.words[idx_ff];
   assign rsp_run_last = (idx_ff == job_data.last_idx);
   assign taken        = rsp_pop & ~job_empty;
   assign job_pop      = taken & rsp_run_last;

   always_comb begin
      idx_in = idx_ff;
      if (taken) begin
         idx_in = rsp_run_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire
